[rtl/kvbrd_pkg.sv]
`default_nettype none

package kvbrd_pkg;

  localparam int HEADER_BYTES     = 24;
  localparam int LEN_BITS_DEFAULT = 32;
  localparam int KEY_LEN_W        = 16;
  localparam int EXTRAS_LEN_W     = 8;
  localparam int HDR_IDX_W        = 5;

  // Positions within the request header.
  localparam logic [HDR_IDX_W-1:0] HDR_MAGIC     = 5'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_OPCODE    = 5'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_KEY_HI    = 5'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_KEY_LO    = 5'd3;
  localparam logic [HDR_IDX_W-1:0] HDR_EXTRAS    = 5'd4;
  localparam logic [HDR_IDX_W-1:0] HDR_DTYPE     = 5'd5;
  localparam logic [HDR_IDX_W-1:0] HDR_BODY0     = 5'd8;
  localparam logic [HDR_IDX_W-1:0] HDR_BODY1     = 5'd9;
  localparam logic [HDR_IDX_W-1:0] HDR_BODY2     = 5'd10;
  localparam logic [HDR_IDX_W-1:0] HDR_BODY3     = 5'd11;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_CHECK = 5'd12;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST      = HDR_IDX_W'(HEADER_BYTES - 1);

  localparam logic [7:0] MAGIC_REQUEST  = 8'h80;
  localparam logic [7:0] MAGIC_RESPONSE = 8'h81;
  localparam logic [7:0] DATA_TYPE_RAW  = 8'h00;

  localparam logic [7:0] OP_GET        = 8'h00;
  localparam logic [7:0] OP_SET        = 8'h01;
  localparam logic [7:0] OP_ADD        = 8'h02;
  localparam logic [7:0] OP_REPLACE    = 8'h03;
  localparam logic [7:0] OP_DELETE     = 8'h04;
  localparam logic [7:0] OP_INCREMENT  = 8'h05;
  localparam logic [7:0] OP_DECREMENT  = 8'h06;
  localparam logic [7:0] OP_QUIT       = 8'h07;
  localparam logic [7:0] OP_FLUSH      = 8'h08;
  localparam logic [7:0] OP_GETQ       = 8'h09;
  localparam logic [7:0] OP_NOOP       = 8'h0a;
  localparam logic [7:0] OP_VERSION    = 8'h0b;
  localparam logic [7:0] OP_GETK       = 8'h0c;
  localparam logic [7:0] OP_GETKQ      = 8'h0d;
  localparam logic [7:0] OP_APPEND     = 8'h0e;
  localparam logic [7:0] OP_PREPEND    = 8'h0f;
  localparam logic [7:0] OP_STAT       = 8'h10;
  localparam logic [7:0] OP_SETQ       = 8'h11;
  localparam logic [7:0] OP_ADDQ       = 8'h12;
  localparam logic [7:0] OP_REPLACEQ   = 8'h13;
  localparam logic [7:0] OP_DELETEQ    = 8'h14;
  localparam logic [7:0] OP_INCREMENTQ = 8'h15;
  localparam logic [7:0] OP_DECREMENTQ = 8'h16;
  localparam logic [7:0] OP_QUITQ      = 8'h17;
  localparam logic [7:0] OP_FLUSHQ     = 8'h18;
  localparam logic [7:0] OP_APPENDQ    = 8'h19;
  localparam logic [7:0] OP_PREPENDQ   = 8'h1a;
  localparam logic [7:0] OP_TOUCH      = 8'h1c;
  localparam logic [7:0] OP_GAT        = 8'h1d;
  localparam logic [7:0] OP_GATQ       = 8'h1e;

  localparam logic [1:0] SEC_HEADER = 2'd0;
  localparam logic [1:0] SEC_EXTRAS = 2'd1;
  localparam logic [1:0] SEC_KEY    = 2'd2;
  localparam logic [1:0] SEC_VALUE  = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_EXTRAS = 3'd1,
    PH_KEY    = 3'd2,
    PH_VALUE  = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    CLS_SET     = 4'd0,
    CLS_ADD     = 4'd1,
    CLS_REPLACE = 4'd2,
    CLS_APPEND  = 4'd3,
    CLS_PREPEND = 4'd4,
    CLS_GET     = 4'd5,
    CLS_DELETE  = 4'd6,
    CLS_INCR    = 4'd7,
    CLS_DECR    = 4'd8,
    CLS_TOUCH   = 4'd9,
    CLS_STATS   = 4'd10,
    CLS_VERSION = 4'd11,
    CLS_QUIT    = 4'd12,
    CLS_FLUSH   = 4'd13
  } cmd_class_t;

  typedef struct packed {
    cmd_class_t cls;
    logic       quiet;
    logic       ret_key;
  } flags_t;

  typedef struct packed {
    logic   known;
    flags_t flags;
  } decode_t;

endpackage

`default_nettype wire

[rtl/kvbrd_opcode_decode.sv]
`default_nettype none

module kvbrd_opcode_decode
  import kvbrd_pkg::*;
(
  input  wire logic [7:0] opcode,
  output decode_t         decoded
);

  function automatic decode_t mk(input cmd_class_t cls, input logic quiet,
                                 input logic ret_key);
    decode_t d;
    d.known         = 1'b1;
    d.flags.cls     = cls;
    d.flags.quiet   = quiet;
    d.flags.ret_key = ret_key;
    return d;
  endfunction

  // No-op is deliberately absent and so counts as unknown.
  always_comb begin
    case (opcode)
      OP_SET:        decoded = mk(CLS_SET, 1'b0, 1'b0);
      OP_SETQ:       decoded = mk(CLS_SET, 1'b1, 1'b0);
      OP_ADD:        decoded = mk(CLS_ADD, 1'b0, 1'b0);
      OP_ADDQ:       decoded = mk(CLS_ADD, 1'b1, 1'b0);
      OP_REPLACE:    decoded = mk(CLS_REPLACE, 1'b0, 1'b0);
      OP_REPLACEQ:   decoded = mk(CLS_REPLACE, 1'b1, 1'b0);
      OP_APPEND:     decoded = mk(CLS_APPEND, 1'b0, 1'b0);
      OP_APPENDQ:    decoded = mk(CLS_APPEND, 1'b1, 1'b0);
      OP_PREPEND:    decoded = mk(CLS_PREPEND, 1'b0, 1'b0);
      OP_PREPENDQ:   decoded = mk(CLS_PREPEND, 1'b1, 1'b0);
      OP_GET:        decoded = mk(CLS_GET, 1'b0, 1'b0);
      OP_GETQ:       decoded = mk(CLS_GET, 1'b1, 1'b0);
      OP_GETK:       decoded = mk(CLS_GET, 1'b0, 1'b1);
      OP_GETKQ:      decoded = mk(CLS_GET, 1'b1, 1'b1);
      OP_DELETE:     decoded = mk(CLS_DELETE, 1'b0, 1'b0);
      OP_DELETEQ:    decoded = mk(CLS_DELETE, 1'b1, 1'b0);
      OP_INCREMENT:  decoded = mk(CLS_INCR, 1'b0, 1'b0);
      OP_INCREMENTQ: decoded = mk(CLS_INCR, 1'b1, 1'b0);
      OP_DECREMENT:  decoded = mk(CLS_DECR, 1'b0, 1'b0);
      OP_DECREMENTQ: decoded = mk(CLS_DECR, 1'b1, 1'b0);
      OP_TOUCH:      decoded = mk(CLS_TOUCH, 1'b0, 1'b0);
      OP_GAT:        decoded = mk(CLS_TOUCH, 1'b0, 1'b0);
      OP_GATQ:       decoded = mk(CLS_TOUCH, 1'b0, 1'b0);
      OP_STAT:       decoded = mk(CLS_STATS, 1'b0, 1'b0);
      OP_VERSION:    decoded = mk(CLS_VERSION, 1'b0, 1'b0);
      OP_QUIT:       decoded = mk(CLS_QUIT, 1'b0, 1'b0);
      OP_QUITQ:      decoded = mk(CLS_QUIT, 1'b1, 1'b0);
      OP_FLUSH:      decoded = mk(CLS_FLUSH, 1'b0, 1'b0);
      OP_FLUSHQ:     decoded = mk(CLS_FLUSH, 1'b1, 1'b0);
      default:       decoded = decode_t'('0);
    endcase
  end

endmodule

`default_nettype wire

[rtl/kv_binary_request_deframer.sv]
// Channel   Direction  Handshake                 Payload
// data      in         data_valid / data_stall   data_byte
// result    out        result_valid / result_stall
//                                                byte_out, section, section_last,
//                                                request_done, command_class,
//                                                quiet_flag, return_key_flag,
//                                                parse_error
//
// One byte per cycle unless stalled; each taken byte yields a registered result.
// The result register is refilled in the cycle it is taken, so the rate is
// set only by the section counter and the result register.
// The value length and the length check are worked out on header byte 12,
// leaving the last header byte with only the opcode decode and a select.
// rst is synchronous and active high; after it the block expects a header.
// A stall on the result side stalls the data side only while a result waits.
`default_nettype none

module kv_binary_request_deframer
  import kvbrd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       data_valid,
  output logic            data_stall,
  input  wire logic [7:0] data_byte,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      byte_out,
  output logic [1:0]      section,
  output logic            section_last,
  output logic            request_done,
  output logic [3:0]      command_class,
  output logic            quiet_flag,
  output logic            return_key_flag,
  output logic            parse_error
);

  localparam int DIFF_W = LEN_BITS + 2;

  phase_t                    phase, phase_next;
  logic [HDR_IDX_W-1:0]      header_index, header_index_next;
  logic [KEY_LEN_W-1:0]      key_len, key_len_next;
  logic [EXTRAS_LEN_W-1:0]   extras_len, extras_len_next;
  logic [LEN_BITS-1:0]       body_len, body_len_next;
  logic [LEN_BITS-1:0]       value_len, value_len_next;
  logic [LEN_BITS-1:0]       remaining, remaining_next;
  logic [7:0]                opcode, opcode_next;
  logic                      header_bad, header_bad_next;
  logic                      len_bad, len_bad_next;
  flags_t                    flags, flags_next;

  logic                      take;
  decode_t                   decoded;
  logic [DIFF_W-1:0]         len_diff;
  logic                      header_last;
  logic                      header_fail;
  logic                      remaining_one;
  phase_t                    adv_phase;
  logic [LEN_BITS-1:0]       adv_len;
  logic                      adv_done;

  logic [1:0]                sec_c;
  logic                      last_c;
  logic                      done_c;
  logic                      err_c;

  kvbrd_opcode_decode u_decode (
    .opcode  (opcode),
    .decoded (decoded)
  );

  assign data_stall    = result_valid && result_stall;
  assign take          = data_valid && !data_stall;
  assign len_diff      = DIFF_W'(body_len) - DIFF_W'(key_len) - DIFF_W'(extras_len);
  assign header_last   = (header_index == HDR_LAST);
  assign header_fail   = header_bad || !decoded.known || len_bad;
  assign remaining_one = (remaining[LEN_BITS-1:1] == '0);

  // Next non-empty section after the current one.
  always_comb begin
    adv_phase = PH_HEADER;
    adv_len   = '0;
    adv_done  = 1'b1;
    case (phase)
      PH_HEADER: begin
        if (extras_len != '0) begin
          adv_phase = PH_EXTRAS;
          adv_len   = LEN_BITS'(extras_len);
          adv_done  = 1'b0;
        end else if (key_len != '0) begin
          adv_phase = PH_KEY;
          adv_len   = LEN_BITS'(key_len);
          adv_done  = 1'b0;
        end else if (value_len != '0) begin
          adv_phase = PH_VALUE;
          adv_len   = value_len;
          adv_done  = 1'b0;
        end
      end
      PH_EXTRAS: begin
        if (key_len != '0) begin
          adv_phase = PH_KEY;
          adv_len   = LEN_BITS'(key_len);
          adv_done  = 1'b0;
        end else if (value_len != '0) begin
          adv_phase = PH_VALUE;
          adv_len   = value_len;
          adv_done  = 1'b0;
        end
      end
      PH_KEY: begin
        if (value_len != '0) begin
          adv_phase = PH_VALUE;
          adv_len   = value_len;
          adv_done  = 1'b0;
        end
      end
      default: begin
        adv_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    key_len_next      = key_len;
    extras_len_next   = extras_len;
    body_len_next     = body_len;
    value_len_next    = value_len;
    remaining_next    = remaining;
    opcode_next       = opcode;
    header_bad_next   = header_bad;
    len_bad_next      = len_bad;
    flags_next        = flags;
    case (phase)
      PH_HEADER: begin
        case (header_index)
          HDR_MAGIC: begin
            header_bad_next = (data_byte != MAGIC_REQUEST) &&
                              (data_byte != MAGIC_RESPONSE);
            flags_next      = flags_t'('0);
          end
          HDR_OPCODE: opcode_next = data_byte;
          HDR_KEY_HI: key_len_next = {data_byte, 8'h00};
          HDR_KEY_LO: key_len_next = {key_len[KEY_LEN_W-1:8], data_byte};
          HDR_EXTRAS: extras_len_next = data_byte;
          HDR_DTYPE: header_bad_next = header_bad || (data_byte != DATA_TYPE_RAW);
          HDR_BODY0, HDR_BODY1, HDR_BODY2, HDR_BODY3: begin
            body_len_next = {body_len[LEN_BITS-9:0], data_byte};
          end
          HDR_LEN_CHECK: begin
            value_len_next = len_diff[LEN_BITS-1:0];
            len_bad_next   = len_diff[DIFF_W-1];
          end
          default: begin
            header_bad_next = header_bad;
          end
        endcase
        if (header_last) begin
          header_index_next = '0;
          if (header_fail) begin
            phase_next = PH_ERROR;
            flags_next = flags_t'('0);
          end else begin
            phase_next     = adv_phase;
            remaining_next = adv_len;
            flags_next     = decoded.flags;
          end
        end else begin
          header_index_next = header_index + HDR_IDX_W'(1);
        end
      end
      PH_EXTRAS, PH_KEY, PH_VALUE: begin
        if (remaining_one) begin
          phase_next     = adv_phase;
          remaining_next = adv_len;
        end else begin
          remaining_next = remaining - LEN_BITS'(1);
        end
      end
      default: begin
        phase_next = PH_ERROR;
        flags_next = flags_t'('0);
      end
    endcase
  end

  always_comb begin
    sec_c  = SEC_HEADER;
    last_c = 1'b0;
    done_c = 1'b0;
    err_c  = 1'b0;
    case (phase)
      PH_HEADER: begin
        last_c = header_last;
        err_c  = header_last && header_fail;
        done_c = header_last && !header_fail && adv_done;
      end
      PH_EXTRAS: begin
        sec_c  = SEC_EXTRAS;
        last_c = remaining_one;
        done_c = remaining_one && adv_done;
      end
      PH_KEY: begin
        sec_c  = SEC_KEY;
        last_c = remaining_one;
        done_c = remaining_one && adv_done;
      end
      PH_VALUE: begin
        sec_c  = SEC_VALUE;
        last_c = remaining_one;
        done_c = remaining_one && adv_done;
      end
      default: begin
        err_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_index <= '0;
      remaining    <= '0;
      header_bad   <= 1'b0;
      len_bad      <= 1'b0;
      flags        <= flags_t'('0);
    end else if (take) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      remaining    <= remaining_next;
      header_bad   <= header_bad_next;
      len_bad      <= len_bad_next;
      flags        <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_len    <= key_len_next;
      extras_len <= extras_len_next;
      body_len   <= body_len_next;
      value_len  <= value_len_next;
      opcode     <= opcode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_out        <= data_byte;
      section         <= sec_c;
      section_last    <= last_c;
      request_done    <= done_c;
      command_class   <= flags_next.cls;
      quiet_flag      <= flags_next.quiet;
      return_key_flag <= flags_next.ret_key;
      parse_error     <= err_c;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |=> phase == PH_ERROR)
    else $error("error phase was left without reset");

  a_index_outside_header: assert property (@(posedge clk) disable iff (rst)
    phase != PH_HEADER |-> header_index == '0)
    else $error("header index not cleared outside the header");

  a_section_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EXTRAS || phase == PH_KEY || phase == PH_VALUE) |-> remaining != '0)
    else $error("section entered with nothing left to transfer");

  a_error_flags_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |-> flags == flags_t'('0))
    else $error("command flags held while in error");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && request_done |-> section_last && !parse_error)
    else $error("request completion without a section end");

endmodule

`default_nettype wire
